/* design/adpo2_pkg.sv */
// Shared types, constants and helpers for the order-2 ADPCM decoder.
// No dependencies; the engine, result queue, top level and testbench import this package.
`timescale 1ns / 1ps

package adpo2_pkg;

	localparam int PREDICTORS_DEF = 8;
	localparam int OUT_DEPTH = 8;
	localparam int MAX_PER_BYTE = 4;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_BYTE  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [1:0] MODE_KEEP = 2'd0;
	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_LOOP = 2'd2;

	localparam logic [1:0] REG_LOOP_LAST   = 2'd0;
	localparam logic [1:0] REG_LOOP_BEFORE = 2'd1;

	typedef struct packed {
		logic               en;
		logic [6:0]         addr;
		logic signed [15:0] data;
	} book_wr_t;

	typedef struct packed {
		logic               en;
		logic [1:0]         mode;
		logic signed [15:0] loop_last;
		logic signed [15:0] loop_before;
	} hist_set_t;

	typedef struct packed {
		logic             en;
		logic [3:0]       pred;
		logic [2:0]       first;
		logic [1:0]       last_s;
		logic             frame_end;
		logic [3:0][15:0] res;
	} byte_cmd_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] sample;
		logic        last_of_byte;
		logic        frame_end;
	} result_t;

	typedef struct packed {
		logic busy;
		logic drained;
	} eng_status_t;

	// Arithmetic shift right by 11 followed by a clamp to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [31:0] acc);
		logic signed [20:0] sh;
		sh = 21'(acc >>> 11);
		if (sh > 21'sd32767) begin
			return 16'sh7fff;
		end else if (sh < -21'sd32768) begin
			return 16'sh8000;
		end else begin
			return sh[15:0];
		end
	endfunction

endpackage

/* design/adpo2_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module adpo2_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/adpo2_ofifo.sv */
// Result queue between the multiply-accumulate pipeline and the output channel.
// Depends on adpo2_pkg for the result type.
`timescale 1ns / 1ps

module adpo2_ofifo #(
	parameter int DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adpo2_pkg::result_t    push,
	input  logic                  pop,
	output logic                  not_empty,
	output logic [15:0]           sample,
	output logic                  last_of_byte,
	output logic                  frame_end
);
	import adpo2_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [17:0]   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= {push.sample, push.last_of_byte, push.frame_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.valid) - CW'(do_pop);
		end
	end

	assign not_empty    = (count_q != '0);
	assign sample       = mem_q[rd_ptr_q][17:2];
	assign last_of_byte = mem_q[rd_ptr_q][1];
	assign frame_end    = mem_q[rd_ptr_q][0];

endmodule

/* design/adpo2_engine.sv */
// Sample engine: codebook RAM, history and group residual registers, and the
// issue / multiply / accumulate pipeline. Depends on adpo2_pkg and adpo2_ram.
`timescale 1ns / 1ps

module adpo2_engine #(
	parameter int PREDICTORS = adpo2_pkg::PREDICTORS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  adpo2_pkg::book_wr_t    book_wr,
	input  adpo2_pkg::hist_set_t   hist_set,
	input  adpo2_pkg::byte_cmd_t   byte_cmd,
	output adpo2_pkg::eng_status_t status,
	output adpo2_pkg::result_t     result
);
	import adpo2_pkg::*;

	localparam int BOOK_WORDS = PREDICTORS * 16;
	localparam int AW = $clog2(BOOK_WORDS);

	// Byte being issued.
	logic             busy_q;
	logic [3:0]       pred_q;
	logic [2:0]       first_q;
	logic [1:0]       last_s_q;
	logic             fe_q;
	logic [3:0][15:0] res_q;
	logic [1:0]       s_q;
	logic [3:0]       t_q;

	logic signed [15:0] hist_last_q, hist_before_q;
	logic signed [15:0] gp_last_q, gp_before_q;
	logic [15:0]        gres_q [7];

	// Pipeline.
	logic               v_s1, first_s1, last_s1, lob_s1, fe_s1;
	logic signed [15:0] opnd_s1, r_s1;
	logic               v_s2, first_s2, last_s2, lob_s2, fe_s2;
	logic signed [31:0] prod_s2;
	logic signed [15:0] r_s2;
	logic signed [31:0] acc_q;

	logic [2:0]         j;
	logic [3:0]         j4;
	logic               stall, issue, term_last;
	logic [2:0]         tap_k;
	logic [3:0]         offset;
	logic [AW-1:0]      rd_addr;
	logic signed [15:0] opnd;
	logic [2:0]         gidx;
	logic [15:0]        rdata;
	logic signed [31:0] acc_base, acc_sum;
	logic               wr_en;

	assign j  = first_q + 3'(s_q);
	assign j4 = {1'b0, j};

	// The first sample of a group latches the history, so it waits for the
	// samples still in the pipeline to land.
	assign stall     = (t_q == 4'd0) && (j == 3'd0) && (v_s1 || v_s2);
	assign issue     = busy_q && !stall;
	assign term_last = (t_q == j4 + 4'd1);

	assign tap_k  = (t_q == 4'd1) ? j : 3'(j4 + 4'd1 - t_q);
	assign offset = (t_q == 4'd0) ? {1'b0, j} : {1'b1, tap_k};
	assign rd_addr = AW'({pred_q, offset});
	assign gidx   = 3'(t_q - 4'd2);

	always_comb begin
		if (t_q == 4'd0) begin
			opnd = (j == 3'd0) ? hist_before_q : gp_before_q;
		end else if (t_q == 4'd1) begin
			opnd = gp_last_q;
		end else begin
			opnd = $signed(gres_q[gidx]);
		end
	end

	assign wr_en = book_wr.en && ({1'b0, book_wr.addr} < 9'(BOOK_WORDS));

	adpo2_ram #(
		.WIDTH(16),
		.DEPTH(BOOK_WORDS)
	) u_book (
		.clk  (clk),
		.we   (wr_en),
		.waddr(AW'(book_wr.addr)),
		.wdata(book_wr.data),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (byte_cmd.en) begin
			pred_q   <= byte_cmd.pred;
			first_q  <= byte_cmd.first;
			last_s_q <= byte_cmd.last_s;
			fe_q     <= byte_cmd.frame_end;
			res_q    <= byte_cmd.res;
			for (int i = 0; i < MAX_PER_BYTE; i++) begin
				if ((2'(i) <= byte_cmd.last_s) && ({1'b0, byte_cmd.first} + 4'(i) < 4'd7)) begin
					gres_q[3'(byte_cmd.first + 3'(i))] <= byte_cmd.res[i];
				end
			end
		end
		opnd_s1  <= opnd;
		r_s1     <= $signed(res_q[s_q]);
		first_s1 <= (t_q == 4'd0);
		last_s1  <= term_last;
		lob_s1   <= term_last && (s_q == last_s_q);
		fe_s1    <= term_last && (s_q == last_s_q) && fe_q;
		prod_s2  <= $signed(rdata) * opnd_s1;
		r_s2     <= r_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		lob_s2   <= lob_s1;
		fe_s2    <= fe_s1;
		if (v_s2) begin
			acc_q <= acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			s_q           <= '0;
			t_q           <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			hist_last_q   <= '0;
			hist_before_q <= '0;
			gp_last_q     <= '0;
			gp_before_q   <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (byte_cmd.en) begin
				busy_q <= 1'b1;
				s_q    <= '0;
				t_q    <= '0;
			end else if (issue) begin
				if (term_last) begin
					t_q <= '0;
					if (s_q == last_s_q) begin
						busy_q <= 1'b0;
					end else begin
						s_q <= s_q + 2'd1;
					end
				end else begin
					t_q <= t_q + 4'd1;
				end
			end
			if (issue && (t_q == 4'd0) && (j == 3'd0)) begin
				gp_last_q   <= hist_last_q;
				gp_before_q <= hist_before_q;
			end
			if (hist_set.en) begin
				if (hist_set.mode == MODE_ZERO) begin
					hist_last_q   <= '0;
					hist_before_q <= '0;
				end else if (hist_set.mode == MODE_LOOP) begin
					hist_last_q   <= hist_set.loop_last;
					hist_before_q <= hist_set.loop_before;
				end
			end else if (v_s2 && last_s2) begin
				hist_before_q <= hist_last_q;
				hist_last_q   <= sat16(acc_sum);
			end
		end
	end

	assign acc_base = first_s2 ? (32'(r_s2) <<< 11) : acc_q;
	assign acc_sum  = acc_base + prod_s2;

	assign result.valid        = v_s2 && last_s2;
	assign result.sample       = sat16(acc_sum);
	assign result.last_of_byte = lob_s2;
	assign result.frame_end    = fe_s2;

	assign status.busy    = busy_q;
	assign status.drained = !busy_q && !v_s1 && !v_s2;

endmodule

/* design/adpcm_order2_decoder_top.sv */
// Top level of the order-2 ADPCM decoder: input holding register, frame
// parser, loop registers and result credit. Depends on adpo2_pkg, adpo2_engine
// and adpo2_ofifo.
//
//   channel  signals                                          direction
//   in       in_valid/in_ready, action..stream_byte           item in
//   out      out_valid/out_ready, sample, last_of_byte, ...   item out
//   cfg      cfg_we, cfg_index, cfg_data                      write only
//
// Each sample j of a group (0..7) sums j+2 products on the single codebook read
// port and multiplier, and a data byte's samples are issued in turn. Headers
// are taken without waiting; loads wait for the engine to go idle and starts
// for it to drain. Results pass the s1 and s2 pipeline registers and wait in
// an 8-entry queue; a data byte enters the engine only when the queue has room for it.
// Reset clears control state; the codebook is not cleared.
`timescale 1ns / 1ps

module adpcm_order2_decoder_top #(
	parameter int PREDICTORS = adpo2_pkg::PREDICTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [6:0]         book_index,
	input  logic signed [15:0] book_word,
	input  logic [1:0]         start_mode,
	input  logic               narrow_codes,
	input  logic [7:0]         stream_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               last_of_byte,
	output logic               frame_end,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import adpo2_pkg::*;

	localparam int RW = $clog2(OUT_DEPTH + 1);

	logic               hold_v_q;
	action_t            hold_act_q;
	logic [6:0]         hold_idx_q;
	logic signed [15:0] hold_word_q;
	logic [1:0]         hold_mode_q;
	logic               hold_narrow_q;
	logic [7:0]         hold_byte_q;

	logic signed [15:0] loop_last_q, loop_before_q;
	logic [3:0]         pos_q, shift_q, pred_q;
	logic               narrow_q;
	logic [RW-1:0]      resv_q;

	eng_status_t st;
	byte_cmd_t   bcmd;
	book_wr_t    bwr;
	hist_set_t   hset;
	result_t     res;

	logic       accept, consume, can_go, is_header, data_go, pop;
	logic [3:0] nbytes, pos_m1;
	logic [4:0] pm;
	logic [3:0][15:0] resid;
	logic [2:0] per;

	assign nbytes    = narrow_q ? 4'd4 : 4'd8;
	assign pos_m1    = pos_q - 4'd1;
	assign is_header = (pos_q == 4'd0) || (pos_q > nbytes);
	assign per       = narrow_q ? 3'd4 : 3'd2;

	always_comb begin
		case (hold_act_q)
			ACT_LOAD:  can_go = !st.busy;
			ACT_START: can_go = st.drained;
			ACT_BYTE:  can_go = is_header ||
				(!st.busy && (resv_q <= RW'(OUT_DEPTH - MAX_PER_BYTE)));
			default:   can_go = 1'b1;
		endcase
	end

	assign consume  = hold_v_q && can_go;
	assign in_ready = !hold_v_q || consume;
	assign accept   = in_valid && in_ready;
	assign data_go  = consume && (hold_act_q == ACT_BYTE) && !is_header;
	assign pop      = out_valid && out_ready;

	// Header predictor taken modulo the predictor count.
	always_comb begin
		pm = {2'b00, hold_byte_q[2:0]};
		for (int i = 0; i < 8; i++) begin
			if (pm >= 5'(PREDICTORS)) begin
				pm = pm - 5'(PREDICTORS);
			end
		end
	end

	always_comb begin
		logic signed [15:0] ext;
		for (int i = 0; i < MAX_PER_BYTE; i++) begin
			if (narrow_q) begin
				ext = 16'(signed'(hold_byte_q[7 - 2 * i -: 2]));
			end else if (i == 0) begin
				ext = 16'(signed'(hold_byte_q[7:4]));
			end else if (i == 1) begin
				ext = 16'(signed'(hold_byte_q[3:0]));
			end else begin
				ext = '0;
			end
			resid[i] = 16'(ext << shift_q);
		end
	end

	assign bcmd.en        = data_go;
	assign bcmd.pred      = pred_q;
	assign bcmd.first     = narrow_q ? {pos_m1[0], 2'b00} : {pos_m1[1:0], 1'b0};
	assign bcmd.last_s    = narrow_q ? 2'd3 : 2'd1;
	assign bcmd.frame_end = (pos_q == nbytes);
	assign bcmd.res       = resid;

	assign bwr.en   = consume && (hold_act_q == ACT_LOAD);
	assign bwr.addr = hold_idx_q;
	assign bwr.data = hold_word_q;

	assign hset.en          = consume && (hold_act_q == ACT_START);
	assign hset.mode        = hold_mode_q;
	assign hset.loop_last   = loop_last_q;
	assign hset.loop_before = loop_before_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_act_q    <= action_t'(action);
			hold_idx_q    <= book_index;
			hold_word_q   <= book_word;
			hold_mode_q   <= start_mode;
			hold_narrow_q <= narrow_codes;
			hold_byte_q   <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q      <= 1'b0;
			loop_last_q   <= '0;
			loop_before_q <= '0;
			pos_q         <= '0;
			shift_q       <= '0;
			pred_q        <= '0;
			narrow_q      <= 1'b0;
			resv_q        <= '0;
		end else begin
			if (accept) begin
				hold_v_q <= 1'b1;
			end else if (consume) begin
				hold_v_q <= 1'b0;
			end
			if (cfg_we && (cfg_index == REG_LOOP_LAST)) begin
				loop_last_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == REG_LOOP_BEFORE)) begin
				loop_before_q <= cfg_data;
			end
			if (consume && (hold_act_q == ACT_START)) begin
				narrow_q <= hold_narrow_q;
				pos_q    <= '0;
			end else if (consume && (hold_act_q == ACT_BYTE)) begin
				if (is_header) begin
					shift_q <= hold_byte_q[7:4];
					pred_q  <= pm[3:0];
					pos_q   <= 4'd1;
				end else begin
					pos_q <= (pos_q == nbytes) ? 4'd0 : pos_q + 4'd1;
				end
			end
			resv_q <= resv_q + (data_go ? RW'(per) : RW'(0)) - RW'(pop);
		end
	end

	adpo2_engine #(
		.PREDICTORS(PREDICTORS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.book_wr (bwr),
		.hist_set(hset),
		.byte_cmd(bcmd),
		.status  (st),
		.result  (res)
	);

	adpo2_ofifo #(
		.DEPTH(OUT_DEPTH)
	) u_ofifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (res),
		.pop         (pop),
		.not_empty   (out_valid),
		.sample      (sample),
		.last_of_byte(last_of_byte),
		.frame_end   (frame_end)
	);

endmodule

/* design/adpo2_checker.sv */
// Port-level checks for the order-2 ADPCM decoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module adpo2_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample,
	input logic        last_of_byte,
	input logic        frame_end
);

	// A waiting result item holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) &&
		$stable(last_of_byte) && $stable(frame_end))
		else $error("output item changed while stalled");

	// The end of a frame is always the end of a byte.
	a_fe_lob: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_byte)
		else $error("frame end without last of byte");

	// The input side only closes after it has taken an item.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready fell without an accepted item");

endmodule

bind adpcm_order2_decoder_top adpo2_checker u_adpo2_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.sample      (sample),
	.last_of_byte(last_of_byte),
	.frame_end   (frame_end)
);

/* bench/tb_adpcm_order2_decoder_top.sv */
// Testbench for adpcm_order2_decoder_top: directed frames, then random frames,
// each sample checked against an order-2 ADPCM predictor kept in this file.
// Depends on adpo2_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_adpcm_order2_decoder_top;
	import adpo2_pkg::*;

	typedef struct {
		logic signed [15:0] sample;
		logic               last_of_byte;
		logic               frame_end;
	} pcm_t;

	typedef struct {
		action_t            act;
		logic [6:0]         idx;
		logic signed [15:0] word;
		logic [1:0]         mode;
		logic               narrow;
		logic [7:0]         data;
		bit                 typed;
		logic signed [15:0] last_sample;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         action = ACT_NONE;
	logic [6:0]         book_index = '0;
	logic signed [15:0] book_word = '0;
	logic [1:0]         start_mode = MODE_KEEP;
	logic               narrow_codes = 1'b0;
	logic [7:0]         stream_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] sample;
	logic               last_of_byte;
	logic               frame_end;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	adpcm_order2_decoder_top uut (.*);

	// Decoder state as the testbench tracks it.
	logic signed [15:0] book [128];
	logic signed [15:0] loop_last, loop_before;
	logic signed [15:0] hist_last, hist_before, grp_last, grp_before;
	logic signed [15:0] grp_res [7];
	logic [3:0]         shift_amt, byte_pos;
	logic [2:0]         pred;
	logic               narrow_mode;

	pcm_t pending_pcm[$];
	bit   idle_on = 1'b1;
	int   mismatches = 0;
	int   items_sent = 0;
	int   samples_seen = 0;
	int   frames_seen = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic signed [15:0] clamp_acc(input int acc);
		int t;
		t = acc >>> 11;
		if (t > 32767) return 16'sh7fff;
		if (t < -32768) return 16'sh8000;
		return t[15:0];
	endfunction

	// Decodes one stream byte and queues the samples it yields.
	task automatic decode_byte(input logic [7:0] b);
		logic [3:0]         nbytes;
		logic [2:0]         first, j;
		int                 per, acc, base;
		logic [3:0]         code;
		logic signed [15:0] cs, r, y;
		pcm_t               p;
		nbytes = narrow_mode ? 4'd4 : 4'd8;
		per = narrow_mode ? 4 : 2;
		if (byte_pos == 0 || byte_pos > nbytes) begin
			shift_amt = b[7:4];
			pred = b[2:0];
			byte_pos = 4'd1;
			return;
		end
		first = narrow_mode ? 3'(((byte_pos - 1) & 1) * 4) : 3'(((byte_pos - 1) & 3) * 2);
		base = pred * 16;
		for (int s = 0; s < per; s++) begin
			j = first + 3'(s);
			if (narrow_mode) begin
				code = {2'b00, b[7 - 2 * s -: 2]};
				cs = {{14{code[1]}}, code[1:0]};
			end else begin
				code = b[7 - 4 * s -: 4];
				cs = {{12{code[3]}}, code};
			end
			r = cs << shift_amt;
			if (j == 0) begin
				grp_last = hist_last;
				grp_before = hist_before;
			end
			acc = int'(book[base + j]) * int'(grp_before)
				+ int'(book[base + 8 + j]) * int'(grp_last) + (int'(r) <<< 11);
			for (int k = 0; k < j; k++)
				acc += int'(book[base + 8 + (j - k - 1)]) * int'(grp_res[k]);
			if (j < 7) grp_res[j] = r;
			y = clamp_acc(acc);
			hist_before = hist_last;
			hist_last = y;
			p.sample = y;
			p.last_of_byte = (s == per - 1);
			p.frame_end = (s == per - 1) && (byte_pos == nbytes);
			pending_pcm.push_back(p);
		end
		byte_pos = (byte_pos == nbytes) ? 4'd0 : byte_pos + 4'd1;
	endtask

	task automatic apply_item(input stim_row_t it);
		case (it.act)
			ACT_LOAD: book[it.idx] = it.word;
			ACT_START: begin
				if (it.mode == MODE_ZERO) begin
					hist_last = '0;
					hist_before = '0;
				end else if (it.mode == MODE_LOOP) begin
					hist_last = loop_last;
					hist_before = loop_before;
				end
				narrow_mode = it.narrow;
				byte_pos = '0;
			end
			ACT_BYTE: decode_byte(it.data);
			default: ;
		endcase
	endtask

	// Presents one item, holds it until accepted, then updates the prediction.
	task automatic send_item(input stim_row_t it);
		int gap;
		gap = (idle_on && $urandom_range(99) < 35) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		book_index <= it.idx;
		book_word <= it.word;
		start_mode <= it.mode;
		narrow_codes <= it.narrow;
		stream_byte <= it.data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_item(it);
		items_sent++;
		if (it.typed && pending_pcm[$].sample !== it.last_sample) begin
			mismatches++;
			if (mismatches <= 10)
				$display("typed row: byte %h expected last sample %0d, predicted %0d",
					it.data, it.last_sample, pending_pcm[$].sample);
		end
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pcm.size() != 0) @(posedge clk);
		// A trailing header yields nothing but may still sit in the input holding register.
		repeat (40) @(posedge clk);
	endtask

	// Writes both loop registers plus the two unused indexes.
	task automatic write_loop_regs(input logic [15:0] last_v, input logic [15:0] before_v);
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= 2'(i);
			cfg_data <= (i == REG_LOOP_LAST) ? last_v :
				(i == REG_LOOP_BEFORE) ? before_v : 16'($urandom);
			@(posedge clk);
			if (i == REG_LOOP_LAST) loop_last = last_v;
			if (i == REG_LOOP_BEFORE) loop_before = before_v;
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_word;
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		pcm_t e;
		if (out_valid && out_ready) begin
			if (pending_pcm.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample %0d", sample);
			end else begin
				e = pending_pcm.pop_front();
				samples_seen++;
				if (e.frame_end) frames_seen++;
				if (sample !== e.sample || last_of_byte !== e.last_of_byte ||
						frame_end !== e.frame_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample mismatch: expected %0d/%b/%b, got %0d/%b/%b",
							e.sample, e.last_of_byte, e.frame_end,
							sample, last_of_byte, frame_end);
				end
			end
		end
		out_ready <= (idle_on && $urandom_range(99) < 35) ? 1'b0 : 1'b1;
	end

	initial begin
		stim_row_t dir_rows [23];
		stim_row_t it;
		int        n_data, rnd_items, next_cfg;
		logic [3:0] nb;

		for (int i = 0; i < 128; i++) book[i] = '0;
		for (int i = 0; i < 7; i++) grp_res[i] = '0;
		{loop_last, loop_before, hist_last, hist_before, grp_last, grp_before} = '0;
		{shift_amt, byte_pos, pred, narrow_mode} = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_loop_regs(16'h7fff, 16'h8000);

		// Fill the whole codebook first; predictor 7 stays all zero so the
		// directed rows using it give samples equal to their residuals.
		it = '{ACT_LOAD, 0, 0, MODE_KEEP, 0, 0, 0, 0};
		for (int i = 0; i < 128; i++) begin
			it.idx = 7'(i);
			it.word = (i >= 112) ? 16'sh0 : pick_word();
			send_item(it);
		end

		dir_rows = '{
			'{ACT_START, 0, 0, MODE_ZERO, 0, 8'h00, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h07, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h7f, 1, -1},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h80, 1, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h08, 1, -8},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h11, 1, 1},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h00, 1, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'hf0, 1, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h0f, 1, -1},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h77, 1, 7},
			'{ACT_START, 0, 0, MODE_LOOP, 1, 8'h00, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'hf7, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h40, 1, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'hff, 1, -32768},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h03, 1, -32768},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h55, 1, -32768},
			'{ACT_NONE,  0, 0, MODE_KEEP, 0, 8'haa, 0, 0},
			'{ACT_START, 0, 0, 2'd3,      0, 8'h00, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h43, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h9c, 0, 0},
			'{ACT_BYTE,  0, 0, MODE_KEEP, 0, 8'h7f, 0, 0},
			'{ACT_LOAD,  127, 16'sh8000, MODE_KEEP, 0, 8'h00, 0, 0},
			'{ACT_LOAD,  0, 16'sh7fff, MODE_KEEP, 0, 8'h00, 0, 0}
		};
		foreach (dir_rows[i]) send_item(dir_rows[i]);

		// Random part: mostly whole frames with random content, some cut short,
		// some continuing the kept state, plus loads and ignored items.
		rnd_items = 0;
		next_cfg = 120;
		while (rnd_items < 330) begin
			if (rnd_items >= next_cfg) begin
				settle();
				case (next_cfg)
					120: write_loop_regs(16'h8000, 16'h7fff);
					240: write_loop_regs(16'h0000, 16'h0000);
					default: write_loop_regs(pick_word(), pick_word());
				endcase
				next_cfg += 120;
			end
			idle_on = !(rnd_items >= 200 && rnd_items < 290);
			it = '{ACT_BYTE, 0, 0, MODE_KEEP, 0, 0, 0, 0};
			case ($urandom_range(99)) inside
				[0:79]: begin
					if ($urandom_range(9) != 0) begin
						it.act = ACT_START;
						it.mode = 2'($urandom_range(3));
						it.narrow = 1'($urandom_range(1));
						send_item(it);
						rnd_items++;
						it.act = ACT_BYTE;
						it.data = 8'($urandom);
						send_item(it);
						rnd_items++;
					end
					nb = narrow_mode ? 4'd4 : 4'd8;
					n_data = ($urandom_range(99) < 15) ? $urandom_range(nb - 1) : nb;
					for (int i = 0; i < n_data; i++) begin
						it.data = 8'($urandom);
						send_item(it);
						rnd_items++;
					end
				end
				[80:91]: begin
					it.act = ACT_LOAD;
					it.idx = 7'($urandom);
					it.word = pick_word();
					send_item(it);
					rnd_items++;
				end
				default: begin
					it.act = ACT_NONE;
					it.idx = 7'($urandom);
					it.word = 16'($urandom);
					it.mode = 2'($urandom);
					it.narrow = 1'($urandom);
					it.data = 8'($urandom);
					send_item(it);
					rnd_items++;
				end
			endcase
		end

		idle_on = 1'b1;
		settle();
		$display("Sent %0d items; checked %0d samples across %0d complete frames.",
			items_sent, samples_seen, frames_seen);
		$display("Covered 4-bit and 2-bit codes, all history sources and loop settings.");
		if (mismatches == 0 && pending_pcm.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d samples missing", mismatches, pending_pcm.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
